// ===== hw/rtl/csxp_pkg.sv =====
`timescale 1ns / 1ps

package csxp_pkg;

    // Default output value width
    localparam int VALUE_BITS_DEFAULT = 16;

    // Prefix skip count after reset
    localparam logic [3:0] PREFIX_SKIP_RESET = 4'd5;

    // Characters with a meaning in the line format
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VTAB    = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Number conversion phase
    typedef enum logic [2:0] {
        PH_SPACE  = 3'b001,
        PH_DIGITS = 3'b010,
        PH_STOP   = 3'b100
    } conv_phase_t;

    // Field being read
    typedef enum logic [2:0] {
        FLD_X = 3'b001,
        FLD_Y = 3'b010,
        FLD_Z = 3'b100
    } field_sel_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) ||
                   (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== hw/rtl/comma_sentence_xyz_parser.sv =====
`timescale 1ns / 1ps

// Parses a text line of the form <prefix>x,y,z* one byte per transfer on the
// rx_byte channel. After reset or a newline, prefix_skip bytes are dropped, then
// x and y (ending at a comma) and z (ending at an asterisk) are converted like
// atoi: leading whitespace, optional sign, digits up to the first non-digit,
// saturated to VALUE_BITS-bit signed. The asterisk that closes z produces one
// transfer of x_value, y_value, z_value; bytes after it are ignored until the
// next newline. The field state is updated by a single multiply-by-ten-and-add
// per byte, and a byte can be taken every cycle.
// A finished result sits in an output register; only an asterisk that would
// produce another result waits (in_ready low) while that register is still full.
// prefix_skip may only be written while the block is idle.
module comma_sentence_xyz_parser #(
    parameter int VALUE_BITS = csxp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         prefix_skip_we,
    input  logic [3:0]                   prefix_skip,
    // byte input
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   rx_byte,
    // result output
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [VALUE_BITS-1:0] x_value,
    output logic signed [VALUE_BITS-1:0] y_value,
    output logic signed [VALUE_BITS-1:0] z_value
);

    localparam int ACC_W = VALUE_BITS + 4;
    // Magnitude cap, 2^(VALUE_BITS-1)
    localparam logic [ACC_W-1:0] MAG_LIM = {{4{1'b0}}, 1'b1, {(VALUE_BITS-1){1'b0}}};

    // State registers
    logic [3:0]              prefix_skip_reg;
    logic [3:0]              skip_count_reg, skip_count_next;
    csxp_pkg::field_sel_t    field_reg, field_next;
    csxp_pkg::conv_phase_t   phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic [VALUE_BITS-1:0]   mag_reg, mag_next;
    logic [VALUE_BITS-1:0]   held_x_reg, held_x_next;
    logic [VALUE_BITS-1:0]   held_y_reg, held_y_next;
    logic                    line_done_reg, line_done_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]   x_out_reg, y_out_reg, z_out_reg;

    logic                    in_fire;
    logic                    in_prefix;
    logic                    emit_cand;
    logic                    emit;
    logic [ACC_W-1:0]        mag_wide;
    logic [ACC_W-1:0]        mag_prod;
    logic [VALUE_BITS-1:0]   mag_sat;
    logic [VALUE_BITS-1:0]   field_val;

    // Saturated signed value of the field read so far
    always_comb
    begin
        if (neg_reg)
        begin
            field_val = ~mag_reg + {{(VALUE_BITS-1){1'b0}}, 1'b1};
        end
        else if (mag_reg[VALUE_BITS-1])
        begin
            field_val = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
        else
        begin
            field_val = mag_reg;
        end
    end

    // Next magnitude for a digit: acc * 10 + digit, capped
    always_comb
    begin
        mag_wide = {{4{1'b0}}, mag_reg};
        mag_prod = (mag_wide << 3) + (mag_wide << 1) + {{(ACC_W-4){1'b0}}, rx_byte[3:0]};
        mag_sat  = (mag_prod > MAG_LIM) ? MAG_LIM[VALUE_BITS-1:0]
                                        : mag_prod[VALUE_BITS-1:0];
    end

    // Stall only a result-producing byte while the output register is full
    assign in_prefix = skip_count_reg < prefix_skip_reg;
    assign emit_cand = (rx_byte == csxp_pkg::CH_STAR) && !line_done_reg && !in_prefix &&
                       (field_reg == csxp_pkg::FLD_Z);
    assign in_ready  = !(out_valid_reg && !out_ready && emit_cand);
    assign in_fire   = in_valid && in_ready;

    // Per-byte state update
    always_comb
    begin
        skip_count_next = skip_count_reg;
        field_next      = field_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        line_done_next  = line_done_reg;
        emit            = 1'b0;

        if (in_fire)
        begin
            if (rx_byte == csxp_pkg::CH_NL)
            begin
                skip_count_next = '0;
                field_next      = csxp_pkg::FLD_X;
                phase_next      = csxp_pkg::PH_SPACE;
                neg_next        = 1'b0;
                mag_next        = '0;
                line_done_next  = 1'b0;
            end
            else if (!line_done_reg)
            begin
                if (in_prefix)
                begin
                    skip_count_next = skip_count_reg + 4'd1;
                end
                else if ((field_reg != csxp_pkg::FLD_Z) && (rx_byte == csxp_pkg::CH_COMMA))
                begin
                    // end of x or y
                    if (field_reg == csxp_pkg::FLD_X)
                    begin
                        held_x_next = field_val;
                        field_next  = csxp_pkg::FLD_Y;
                    end
                    else
                    begin
                        held_y_next = field_val;
                        field_next  = csxp_pkg::FLD_Z;
                    end
                    phase_next = csxp_pkg::PH_SPACE;
                    neg_next   = 1'b0;
                    mag_next   = '0;
                end
                else if (emit_cand)
                begin
                    // end of z: hand out the result
                    emit           = 1'b1;
                    phase_next     = csxp_pkg::PH_SPACE;
                    neg_next       = 1'b0;
                    mag_next       = '0;
                    line_done_next = 1'b1;
                end
                else
                begin
                    // atoi-style conversion of one character
                    unique case (phase_reg)
                        csxp_pkg::PH_SPACE:
                        begin
                            if (csxp_pkg::is_space(rx_byte))
                            begin
                                phase_next = csxp_pkg::PH_SPACE;
                            end
                            else if ((rx_byte == csxp_pkg::CH_MINUS) ||
                                     (rx_byte == csxp_pkg::CH_PLUS))
                            begin
                                neg_next   = (rx_byte == csxp_pkg::CH_MINUS);
                                phase_next = csxp_pkg::PH_DIGITS;
                            end
                            else if (csxp_pkg::is_digit(rx_byte))
                            begin
                                mag_next   = mag_sat;
                                phase_next = csxp_pkg::PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = csxp_pkg::PH_STOP;
                            end
                        end
                        csxp_pkg::PH_DIGITS:
                        begin
                            if (csxp_pkg::is_digit(rx_byte))
                            begin
                                mag_next = mag_sat;
                            end
                            else
                            begin
                                phase_next = csxp_pkg::PH_STOP;
                            end
                        end
                        csxp_pkg::PH_STOP:
                        begin
                            phase_next = csxp_pkg::PH_STOP;
                        end
                        default:
                        begin
                            phase_next = csxp_pkg::PH_STOP;
                        end
                    endcase
                end
            end
        end
    end

    // Output register valid
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and field state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_skip_reg <= csxp_pkg::PREFIX_SKIP_RESET;
            skip_count_reg  <= '0;
            field_reg       <= csxp_pkg::FLD_X;
            phase_reg       <= csxp_pkg::PH_SPACE;
            neg_reg         <= 1'b0;
            mag_reg         <= '0;
            held_x_reg      <= '0;
            held_y_reg      <= '0;
            line_done_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (prefix_skip_we)
            begin
                prefix_skip_reg <= prefix_skip;
            end
            skip_count_reg <= skip_count_next;
            field_reg      <= field_next;
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            held_x_reg     <= held_x_next;
            held_y_reg     <= held_y_next;
            line_done_reg  <= line_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            x_out_reg <= held_x_reg;
            y_out_reg <= held_y_reg;
            z_out_reg <= field_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_value   = x_out_reg;
    assign y_value   = y_out_reg;
    assign z_value   = z_out_reg;

endmodule

// ===== hw/rtl/csxp_checker.sv =====
`timescale 1ns / 1ps

module csxp_checker #(
    parameter int VALUE_BITS = csxp_pkg::VALUE_BITS_DEFAULT
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         prefix_skip_we,
    input logic [3:0]                   prefix_skip,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [7:0]                   rx_byte,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [VALUE_BITS-1:0] x_value,
    input logic signed [VALUE_BITS-1:0] y_value,
    input logic signed [VALUE_BITS-1:0] z_value
);

    // A stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(x_value) && $stable(y_value) && $stable(z_value)))
        else $error("result changed while stalled");

    // Input stalls only behind a full, stalled output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    // A new result follows an asterisk transfer
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |->
            $past(in_valid && in_ready && (rx_byte == csxp_pkg::CH_STAR)))
        else $error("result without a closing asterisk");

    // A newline never produces a result
    a_nl_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (rx_byte == csxp_pkg::CH_NL) && !out_valid) |=> !out_valid)
        else $error("result after newline");

endmodule

bind comma_sentence_xyz_parser csxp_checker #(.VALUE_BITS(VALUE_BITS)) u_csxp_checker (.*);

// ===== sim/xyz_line_checker.sv =====
`timescale 1ns / 1ps

// Watches the byte and result channels of the xyz line parser, runs its own
// copy of the line parser on every accepted byte and compares each result
// transfer with the oldest predicted x/y/z triple.
module xyz_line_checker
    import csxp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         prefix_skip_we,
    input  logic [3:0]                   prefix_skip,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [7:0]                   rx_byte,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic signed [VALUE_BITS-1:0] x_value,
    input  logic signed [VALUE_BITS-1:0] y_value,
    input  logic signed [VALUE_BITS-1:0] z_value,
    output int                           mismatches,
    output int                           pending,
    output int                           results_checked
);

    localparam longint MAG_LIM = longint'(1) << (VALUE_BITS - 1);

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] x;
        logic signed [VALUE_BITS-1:0] y;
        logic signed [VALUE_BITS-1:0] z;
    } xyz_t;

    xyz_t expected_xyz[$];

    // Parser shadow state
    logic [3:0]                   skip_cfg;
    logic [3:0]                   skipped;
    field_sel_t                   fld;
    conv_phase_t                  phase;
    logic                         neg;
    longint                       acc_mag;
    logic signed [VALUE_BITS-1:0] held_x;
    logic signed [VALUE_BITS-1:0] held_y;
    logic                         line_closed;

    function automatic void restart_field();
        phase   = PH_SPACE;
        neg     = 1'b0;
        acc_mag = 0;
    endfunction

    // Saturated two's complement value of the field read so far
    function automatic logic signed [VALUE_BITS-1:0] field_result();
        longint m;
        m = acc_mag;
        if (neg) begin
            if (m > MAG_LIM)
                m = MAG_LIM;
            return VALUE_BITS'(-m);
        end
        if (m > MAG_LIM - 1)
            m = MAG_LIM - 1;
        return VALUE_BITS'(m);
    endfunction

    // atoi-style conversion of one character
    function automatic void convert_char(input logic [7:0] c);
        longint nxt;
        if (phase == PH_STOP)
            return;
        if (phase == PH_SPACE) begin
            case (c)
                CH_SPACE, CH_TAB, CH_VTAB, CH_FF, CH_CR: return;
                CH_MINUS, CH_PLUS:
                begin
                    neg   = (c == CH_MINUS);
                    phase = PH_DIGITS;
                    return;
                end
                default: phase = PH_DIGITS;
            endcase
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            nxt     = acc_mag * 10 + longint'(c - CH_ZERO);
            acc_mag = (nxt > MAG_LIM) ? MAG_LIM : nxt;
        end else begin
            phase = PH_STOP;
        end
    endfunction

    // One accepted byte; an asterisk closing z queues a triple
    function automatic void parse_byte(input logic [7:0] c);
        xyz_t r;
        if (c == CH_NL) begin
            skipped     = '0;
            fld         = FLD_X;
            line_closed = 1'b0;
            restart_field();
            return;
        end
        if (line_closed)
            return;
        if (skipped < skip_cfg) begin
            skipped = skipped + 4'd1;
            return;
        end
        if (fld != FLD_Z) begin
            if (c == CH_COMMA) begin
                if (fld == FLD_X) begin
                    held_x = field_result();
                    fld    = FLD_Y;
                end else begin
                    held_y = field_result();
                    fld    = FLD_Z;
                end
                restart_field();
            end else begin
                convert_char(c);
            end
            return;
        end
        if (c == CH_STAR) begin
            r.x = held_x;
            r.y = held_y;
            r.z = field_result();
            expected_xyz.push_back(r);
            restart_field();
            line_closed = 1'b1;
            return;
        end
        convert_char(c);
    endfunction

    function automatic void check_result();
        xyz_t want;
        if (expected_xyz.size() == 0) begin
            $display("%0t: result with nothing expected: x %0d y %0d z %0d",
                     $time, x_value, y_value, z_value);
            mismatches++;
            return;
        end
        want = expected_xyz.pop_front();
        results_checked++;
        if (x_value !== want.x) begin
            $display("%0t: x_value expected %0d actual %0d", $time, want.x, x_value);
            mismatches++;
        end
        if (y_value !== want.y) begin
            $display("%0t: y_value expected %0d actual %0d", $time, want.y, y_value);
            mismatches++;
        end
        if (z_value !== want.z) begin
            $display("%0t: z_value expected %0d actual %0d", $time, want.z, z_value);
            mismatches++;
        end
    endfunction

    // Result transfer is checked before the byte of the same edge is parsed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            skip_cfg        = PREFIX_SKIP_RESET;
            skipped         = '0;
            fld             = FLD_X;
            held_x          = '0;
            held_y          = '0;
            line_closed     = 1'b0;
            restart_field();
            expected_xyz.delete();
            mismatches      = 0;
            pending         = 0;
            results_checked = 0;
        end else begin
            if (out_valid && out_ready)
                check_result();
            if (prefix_skip_we)
                skip_cfg = prefix_skip;
            if (in_valid && in_ready)
                parse_byte(rx_byte);
            pending = expected_xyz.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import csxp_pkg::*;

    localparam int VB = VALUE_BITS_DEFAULT;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 prefix_skip_we = 1'b0;
    logic [3:0]           prefix_skip    = 4'd0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic [7:0]           rx_byte        = 8'd0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic signed [VB-1:0] x_value;
    logic signed [VB-1:0] y_value;
    logic signed [VB-1:0] z_value;

    int mismatches;
    int pending;
    int results_checked;

    int         send_idle_pct = 26;
    int         recv_idle_pct = 78;
    int         bytes_sent    = 0;
    int         lines_sent    = 0;
    logic [3:0] prefix_now    = PREFIX_SKIP_RESET;
    logic [7:0] line_q[$];
    logic [7:0] ws_chars[5] = '{CH_SPACE, CH_TAB, CH_VTAB, CH_FF, CH_CR};

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    comma_sentence_xyz_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .prefix_skip_we (prefix_skip_we),
        .prefix_skip    (prefix_skip),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .x_value        (x_value),
        .y_value        (y_value),
        .z_value        (z_value)
    );

    xyz_line_checker #(.VALUE_BITS(VB)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .prefix_skip_we  (prefix_skip_we),
        .prefix_skip     (prefix_skip),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .x_value         (x_value),
        .y_value         (y_value),
        .z_value         (z_value),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // Receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // One byte transfer, with random idle cycles in front of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
        lines_sent++;
    endtask

    // Hold off until every predicted triple has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_prefix(input logic [3:0] v);
        drain_results();
        prefix_skip_we <= 1'b1;
        prefix_skip    <= v;
        @(posedge clk);
        prefix_skip_we <= 1'b0;
        prefix_now = v;
    endtask

    // Any byte but a newline and the given terminator
    function automatic logic [7:0] junk_byte(input logic [7:0] bar);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_NL || b == bar);
        return b;
    endfunction

    // Whitespace, optional sign, digits, maybe trailing junk, then terminator
    function automatic void add_field(input logic [7:0] term);
        int n;
        repeat ($urandom_range(0, 2))
            line_q.push_back(ws_chars[$urandom_range(0, 4)]);
        case ($urandom_range(0, 3))
            0: line_q.push_back(CH_MINUS);
            1: line_q.push_back(CH_PLUS);
            default: ;
        endcase
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
        repeat (n)
            line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                line_q.push_back(junk_byte(term));
        line_q.push_back(term);
    endfunction

    // Mostly well-formed lines; some noise and some cut short by a newline
    task automatic send_random_line();
        int kind;
        kind = $urandom_range(0, 99);
        line_q.delete();
        if (kind < 10) begin
            repeat ($urandom_range(1, 20))
                line_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat (prefix_now)
                line_q.push_back(junk_byte(CH_NL));
            add_field(CH_COMMA);
            add_field(CH_COMMA);
            add_field(CH_STAR);
            if ($urandom_range(0, 9) < 3)
                repeat ($urandom_range(1, 4))
                    line_q.push_back(junk_byte(CH_NL));
            if (kind < 20)
                line_q = line_q[0:$urandom_range(0, line_q.size() - 1)];
        end
        line_q.push_back(CH_NL);
        foreach (line_q[i])
            send_byte(line_q[i]);
        lines_sent++;
        // occasionally let the result side run dry
        if ($urandom_range(0, 14) == 0)
            drain_results();
    endtask

    initial
    begin
        int start;
        logic [3:0] plan[6];

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset prefix length
        send_text("$MAG:32767,-32768,0*\n");
        send_text("$MAG:32768,-32769,+99999*\n");
        send_text("$MAG:\011 -12,\013\014\015+7,  -*\n");
        send_text("$MAG:-0,+,*tail*,9\n");
        send_text("$*,*,12*34,5 6,-6,7*\n");
        send_text("$MAG:1,2\n");
        send_text("$MA\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("GX:3,4,5*\n");

        // Random lines across prefix lengths and idle patterns
        plan = '{4'd0, 4'd15, 4'($urandom_range(1, 14)), 4'd3,
                 4'($urandom_range(1, 14)), 4'd15};
        for (int p = 0; p < 3; p++) begin
            case (p)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 26;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 2; k++) begin
                set_prefix(plan[2 * p + k]);
                start = bytes_sent;
                while (bytes_sent - start < 125)
                    send_random_line();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("%0d bytes in %0d lines sent, %0d xyz results checked",
                 bytes_sent, lines_sent, results_checked);
        $display("prefix lengths 0, 3, 15 and two random ones, under three idle patterns");
        if (mismatches == 0 && pending == 0)
            $display("comma_sentence_xyz_parser: match");
        else
            $display("comma_sentence_xyz_parser: mismatch");
        $finish;
    end

    // Hang guard
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still due", pending);
        $display("comma_sentence_xyz_parser: mismatch");
        $finish;
    end

endmodule
